// File: src/mbi_pkg.sv
// ----------------------------------------------------------------------------
// mbi_pkg
// Shared types, constants and helpers for the escape-time iterator.
// ----------------------------------------------------------------------------
package mbi_pkg;

	localparam int DefFractionBits = 26;
	localparam int DefValueWidth   = 32;

	localparam int InWidth        = 29;
	localparam int CountWidth     = 8;
	localparam int LimitWidth     = 31;
	localparam int CfgAddrWidth   = 2;
	localparam int CfgDataWidth   = LimitWidth;
	localparam int InTdataWidth   = 64;
	localparam int OutTdataWidth  = 32;
	localparam int ColourSumWidth = 12;

	localparam logic [CountWidth-1:0] MaxIterReset = 8'd25;
	localparam logic [LimitWidth-1:0] LimitReset   = 31'd671088640;

	localparam logic [ColourSumWidth-1:0] RedGreenStep = 12'd5;
	localparam logic [ColourSumWidth-1:0] BlueStep     = 12'd10;
	localparam logic [8:0]                ColourMod    = 9'd255;

	typedef enum logic [CfgAddrWidth-1:0] {
		REG_MAX_ITER     = 2'd0,
		REG_ESCAPE_LIMIT = 2'd1
	} cfg_reg_t;

	// status of the iteration core as seen by the top level
	typedef struct packed {
		logic                  idle;
		logic                  done;
		logic [CountWidth-1:0] count;
	} mbi_status_t;

	// x mod 255 by folding the high nibble onto the low byte
	function automatic logic [7:0] mod255(input logic [ColourSumWidth-1:0] x);
		logic [8:0] s;
		s = {1'b0, x[7:0]} + {5'b0, x[11:8]};
		if (s >= ColourMod) begin
			s = s - ColourMod;
		end
		return s[7:0];
	endfunction

endpackage

// File: src/mbi_core.sv
// ----------------------------------------------------------------------------
// mbi_core
// Iterates z = z*z + c on one set of three saturating multipliers, with a
// multiply state and an add/compare state per step.
// ----------------------------------------------------------------------------
module mbi_core
	import mbi_pkg::*;
#(
	parameter int FRACTION_BITS = DefFractionBits,
	parameter int VALUE_WIDTH   = DefValueWidth
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [InWidth-1:0]    c_real,
	input  logic signed [InWidth-1:0]    c_imag,
	input  logic [CountWidth-1:0]        max_iterations,
	input  logic [LimitWidth-1:0]        escape_limit,
	input  logic                         take,
	output mbi_status_t                  status
);

	localparam int VW = VALUE_WIDTH;
	localparam int IW = (VW > InWidth) ? VW : InWidth;
	localparam int CW = (VW > LimitWidth) ? VW : LimitWidth;

	localparam logic signed [IW-1:0] InHi = {{(IW-VW+1){1'b0}}, {(VW-1){1'b1}}};
	localparam logic signed [IW-1:0] InLo = {{(IW-VW+1){1'b1}}, {(VW-1){1'b0}}};
	localparam logic [2*VW-1:0] MagPos = {{(VW+1){1'b0}}, {(VW-1){1'b1}}};
	localparam logic [2*VW-1:0] MagNeg = {{VW{1'b0}}, 1'b1, {(VW-1){1'b0}}};
	localparam logic signed [VW-1:0] ValHi = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] ValLo = {1'b1, {(VW-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} state_t;

	function automatic logic signed [VW-1:0] clamp_in(input logic signed [InWidth-1:0] c);
		logic signed [IW-1:0] e;
		e = IW'(c);
		if (e > InHi) begin
			e = InHi;
		end else if (e < InLo) begin
			e = InLo;
		end
		return e[VW-1:0];
	endfunction

	// product of magnitudes, truncated, signed and saturated
	function automatic logic signed [VW-1:0] sat_mul(input logic signed [VW-1:0] a,
			input logic signed [VW-1:0] b);
		logic            neg;
		logic [VW-1:0]   ma;
		logic [VW-1:0]   mb;
		logic [2*VW-1:0] prod;
		logic [2*VW-1:0] q;
		logic [2*VW-1:0] lim;
		logic [VW-1:0]   mag;
		neg  = a[VW-1] ^ b[VW-1];
		ma   = a[VW-1] ? VW'(-a) : VW'(a);
		mb   = b[VW-1] ? VW'(-b) : VW'(b);
		prod = {{VW{1'b0}}, ma} * {{VW{1'b0}}, mb};
		q    = prod >> FRACTION_BITS;
		lim  = neg ? MagNeg : MagPos;
		mag  = (q > lim) ? lim[VW-1:0] : q[VW-1:0];
		return neg ? signed'(-mag) : signed'(mag);
	endfunction

	function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
			input logic signed [VW-1:0] b, input logic sub);
		logic signed [VW:0] s;
		s = sub ? ({a[VW-1], a} - {b[VW-1], b}) : ({a[VW-1], a} + {b[VW-1], b});
		if (s[VW] != s[VW-1]) begin
			return s[VW] ? ValLo : ValHi;
		end
		return s[VW-1:0];
	endfunction

	state_t                 state_q;
	logic [CountWidth-1:0]  iter_q;
	logic [CountWidth-1:0]  count_q;
	logic signed [VW-1:0]   cr_q;
	logic signed [VW-1:0]   ci_q;
	logic signed [VW-1:0]   zr_q;
	logic signed [VW-1:0]   zi_q;
	logic signed [VW-1:0]   rr_q;
	logic signed [VW-1:0]   ii_q;
	logic signed [VW-1:0]   ri_q;

	logic signed [VW-1:0]   next_re;
	logic signed [VW-1:0]   next_im;
	logic signed [VW-1:0]   norm;
	logic                   escaped;

	always_comb begin
		next_re = sat_add(sat_add(rr_q, ii_q, 1'b1), cr_q, 1'b0);
		next_im = sat_add(sat_add(ri_q, ri_q, 1'b0), ci_q, 1'b0);
		// the squares of the current z double as the magnitude of the last step
		norm    = sat_add(rr_q, ii_q, 1'b0);
		escaped = !norm[VW-1] && (CW'(unsigned'(norm)) > CW'(escape_limit));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cr_q    <= clamp_in(c_real);
						ci_q    <= clamp_in(c_imag);
						zr_q    <= '0;
						zi_q    <= '0;
						iter_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					rr_q    <= sat_mul(zr_q, zr_q);
					ii_q    <= sat_mul(zi_q, zi_q);
					ri_q    <= sat_mul(zr_q, zi_q);
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (iter_q != '0 && escaped) begin
						count_q <= iter_q - 1'b1;
						state_q <= ST_DONE;
					end else if (iter_q == max_iterations) begin
						count_q <= '0;
						state_q <= ST_DONE;
					end else begin
						zr_q    <= next_re;
						zi_q    <= next_im;
						iter_q  <= iter_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign status.idle  = (state_q == ST_IDLE);
	assign status.done  = (state_q == ST_DONE);
	assign status.count = count_q;

endmodule

// File: src/mandelbrot_escape_iterator.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_iterator
// Escape-time count and colour for one point of the complex plane.
// ----------------------------------------------------------------------------
// One point is taken at a time. A point runs through the iteration core as
// pairs of a multiply state and an add/compare state, one pair per step plus
// one for the final check, until it escapes or reaches max_iterations; its
// result is then registered in the output register. Every step goes once
// through the single set of three multipliers. The next point is taken as
// soon as the core has handed its result to the output register, even while
// that result still waits.
module mandelbrot_escape_iterator
	import mbi_pkg::*;
#(
	parameter int FRACTION_BITS = DefFractionBits,
	parameter int VALUE_WIDTH   = DefValueWidth
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CfgAddrWidth-1:0]  cfg_addr,
	input  logic [CfgDataWidth-1:0]  cfg_wdata,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// c_real [28:0], c_imag [57:29], zero pad
	input  logic [InTdataWidth-1:0]  s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// escape_count [7:0], red [15:8], green [23:16], blue [31:24]
	output logic [OutTdataWidth-1:0] m_axis_tdata,
	// inside_set [0]
	output logic                     m_axis_tuser
);

	logic [CountWidth-1:0] max_iter_q;
	logic [LimitWidth-1:0] limit_q;
	logic                  out_valid_q;
	logic [CountWidth-1:0] count_q;
	logic                  inside_q;
	logic [7:0]            red_q;
	logic [7:0]            blue_q;

	mbi_status_t           core_status;
	logic                  slot_free;
	logic [CountWidth-1:0] cnt;

	assign slot_free = !out_valid_q || m_axis_tready;
	assign cnt       = core_status.count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MaxIterReset;
			limit_q    <= LimitReset;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_MAX_ITER:     max_iter_q <= cfg_wdata[CountWidth-1:0];
				REG_ESCAPE_LIMIT: limit_q    <= cfg_wdata[LimitWidth-1:0];
				default:          ;
			endcase
		end
	end

	mbi_core #(
		.FRACTION_BITS (FRACTION_BITS),
		.VALUE_WIDTH   (VALUE_WIDTH)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (s_axis_tvalid && s_axis_tready),
		.c_real         (s_axis_tdata[InWidth-1:0]),
		.c_imag         (s_axis_tdata[2*InWidth-1:InWidth]),
		.max_iterations (max_iter_q),
		.escape_limit   (limit_q),
		.take           (slot_free),
		.status         (core_status)
	);

	assign s_axis_tready = core_status.idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= core_status.done;
		end
	end

	// colour is zero for points inside the set
	always_ff @(posedge clk) begin
		if (slot_free && core_status.done) begin
			count_q  <= cnt;
			inside_q <= (cnt == '0);
			if (cnt == '0) begin
				red_q  <= '0;
				blue_q <= '0;
			end else begin
				red_q  <= mod255(ColourSumWidth'(cnt) * RedGreenStep);
				blue_q <= mod255(ColourSumWidth'(cnt) * BlueStep);
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {blue_q, red_q, red_q, count_q};
	assign m_axis_tuser  = inside_q;

endmodule

// File: src/mbi_checker.sv
// ----------------------------------------------------------------------------
// mbi_checker
// Port-level checks on the escape-time iterator, bound to the top level.
// ----------------------------------------------------------------------------
module mbi_checker
	import mbi_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cfg_we,
	input logic [CfgAddrWidth-1:0]  cfg_addr,
	input logic [CfgDataWidth-1:0]  cfg_wdata,
	input logic                     s_axis_tvalid,
	input logic                     s_axis_tready,
	input logic [InTdataWidth-1:0]  s_axis_tdata,
	input logic                     m_axis_tvalid,
	input logic                     m_axis_tready,
	input logic [OutTdataWidth-1:0] m_axis_tdata,
	input logic                     m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// one point at a time: busy right after an input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while iterating");

	a_inside_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[7:0] == 8'd0)))
		else $error("inside flag disagrees with count");

	a_inside_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[31:8] == 24'd0))
		else $error("inside point not black");

	a_red_green: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:8] == m_axis_tdata[23:16]))
		else $error("red and green differ");

endmodule

bind mandelbrot_escape_iterator mbi_checker u_mbi_checker (.*);

// File: bench/tb_mandelbrot_escape_iterator.sv
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_iterator
// Self-checking bench for the escape-time iterator: directed corner points and
// register extremes, a back-pressure run, then random points under a series of
// register settings. Each accepted point is scored by a fixed-point predictor
// and every output transfer is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_iterator;
	import mbi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     FracBits    = DefFractionBits;
	localparam longint ValMax      = (longint'(1) << (DefValueWidth - 1)) - 1;
	localparam longint ValMin      = -ValMax - 1;
	localparam longint FxOne       = longint'(1) << FracBits;
	localparam longint FxTwo       = 2 * FxOne;
	localparam longint InMin       = -(longint'(1) << (InWidth - 1));
	localparam longint InMax       = (longint'(1) << (InWidth - 1)) - 1;
	localparam int     LongHold    = 400;
	localparam int     TailCycles  = 2 * 255 + 3 + 100;
	localparam int     PhaseItems  = 160;
	localparam int     PhaseCount  = 12;
	localparam int unsigned TimeLimitNs = 50_000_000;

	localparam logic [CfgAddrWidth-1:0] RegSpare2 = 2'd2;
	localparam logic [CfgAddrWidth-1:0] RegSpare3 = 2'd3;

	localparam logic [CfgDataWidth-1:0] LimitFour = 31'd268435456;
	localparam logic [CfgDataWidth-1:0] LimitHigh = 31'd1073741824;
	localparam logic [CfgDataWidth-1:0] LimitTop  = 31'h7fffffff;

	typedef struct {
		logic signed [InWidth-1:0] re;
		logic signed [InWidth-1:0] im;
	} point_t;

	typedef struct packed {
		logic [CountWidth-1:0] count;
		logic                  in_set;
		logic [7:0]            red;
		logic [7:0]            green;
		logic [7:0]            blue;
	} pixel_t;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     cfg_we        = 1'b0;
	logic [CfgAddrWidth-1:0]  cfg_addr      = '0;
	logic [CfgDataWidth-1:0]  cfg_wdata     = '0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	// c_real [28:0], c_imag [57:29], zero pad
	logic [InTdataWidth-1:0]  s_axis_tdata  = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	// escape_count [7:0], red [15:8], green [23:16], blue [31:24]
	logic [OutTdataWidth-1:0] m_axis_tdata;
	// inside_set [0]
	logic                     m_axis_tuser;

	// predictor copy of the registers
	logic [CountWidth-1:0] iter_limit = MaxIterReset;
	logic [LimitWidth-1:0] norm_limit = LimitReset;

	pixel_t pixel_fifo[$];
	pixel_t pixel_want;
	int     mismatch_count = 0;

	bit steady_in     = 1'b0;
	bit steady_out    = 1'b0;
	bit long_hold_req = 1'b0;
	int hold_left     = 0;

	mandelbrot_escape_iterator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// ------------------------------------------------------------------
	// fixed-point predictor
	// ------------------------------------------------------------------
	function automatic longint fx_clamp(longint v);
		if (v > ValMax) return ValMax;
		if (v < ValMin) return ValMin;
		return v;
	endfunction

	// product of magnitudes, truncated, then signed and saturated
	function automatic longint fx_mul(longint a, longint b);
		logic   neg;
		longint ma;
		longint mb;
		longint q;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		q = (ma * mb) >>> FracBits;
		if (neg) begin
			if (q > -ValMin) q = -ValMin;
			return -q;
		end
		if (q > ValMax) q = ValMax;
		return q;
	endfunction

	function automatic pixel_t escape_point(point_t p);
		longint cr;
		longint ci;
		longint zr;
		longint zi;
		longint rr;
		longint ii;
		longint ri;
		longint norm;
		int     count;
		pixel_t px;
		cr = fx_clamp(longint'(p.re));
		ci = fx_clamp(longint'(p.im));
		zr = 0;
		zi = 0;
		count = 0;
		for (int i = 0; i < int'(iter_limit); i++) begin
			rr = fx_mul(zr, zr);
			ii = fx_mul(zi, zi);
			ri = fx_mul(zr, zi);
			zr = fx_clamp(fx_clamp(rr - ii) + cr);
			zi = fx_clamp(fx_clamp(ri + ri) + ci);
			norm = fx_clamp(fx_mul(zr, zr) + fx_mul(zi, zi));
			if (norm > longint'(norm_limit)) begin
				count = i;
				break;
			end
		end
		px.count  = count[CountWidth-1:0];
		px.in_set = (count == 0);
		px.red    = (count == 0) ? 8'd0 : 8'((5 * count) % 255);
		px.green  = px.red;
		px.blue   = (count == 0) ? 8'd0 : 8'((10 * count) % 255);
		return px;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic point_t mk_point(longint re, longint im);
		point_t p;
		p.re = re[InWidth-1:0];
		p.im = im[InWidth-1:0];
		return p;
	endfunction

	function automatic point_t random_point();
		int     r;
		longint re;
		longint im;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			re = longint'($urandom_range(0, 2 * FxTwo)) - FxTwo;
			im = longint'($urandom_range(0, 2 * FxTwo)) - FxTwo;
		end else if (r < 80) begin
			// window around the set, where counts spread out
			re = longint'($urandom_range(0, 5 * FxOne / 2)) - FxTwo;
			im = longint'($urandom_range(0, 5 * FxOne / 2)) - 5 * FxOne / 4;
		end else if (r < 93) begin
			re = longint'($urandom);
			im = longint'($urandom);
		end else begin
			case ($urandom_range(0, 4))
				0: re = InMin;
				1: re = InMax;
				2: re = FxTwo;
				3: re = -FxTwo;
				default: re = 0;
			endcase
			im = ($urandom_range(0, 1) == 0) ? InMin : InMax;
			if ($urandom_range(0, 1) == 0) im = longint'($urandom_range(0, 255)) - 128;
		end
		return mk_point(re, im);
	endfunction

	task automatic set_register(input logic [CfgAddrWidth-1:0] addr,
			input logic [CfgDataWidth-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (addr)
			REG_MAX_ITER:     iter_limit = value[CountWidth-1:0];
			REG_ESCAPE_LIMIT: norm_limit = value[LimitWidth-1:0];
			default: ;
		endcase
	endtask

	// valid stays up after a transfer so back-to-back points need no toggle
	task automatic send_point(input point_t p);
		int gap;
		gap = steady_in ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {{(InTdataWidth - 2 * InWidth){1'b0}}, p.im, p.re};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pixel_fifo.push_back(escape_point(p));
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pixel_fifo.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_reset_defaults();
		send_point(mk_point(0, 0));
		send_point(mk_point(FxTwo, FxTwo));
		send_point(mk_point(-FxTwo, 0));
		send_point(mk_point(InMin, InMin));
		send_point(mk_point(InMax, InMax));
		send_point(mk_point(FxOne / 4, 0));
		send_point(mk_point(FxOne / 4 + FxOne / 64, 0));
		send_point(mk_point(-3 * FxOne / 4, FxOne / 10));
		send_point(mk_point(0, FxOne));
		send_point(mk_point(FxOne, 0));
		send_point(mk_point(-FxTwo, FxTwo));
		send_point(mk_point(FxTwo, -FxTwo));
		drain_results();
	endtask

	task automatic test_register_extremes();
		// no steps at all: everything reads as inside
		set_register(REG_MAX_ITER, 31'd0);
		send_point(mk_point(InMax, InMin));
		send_point(mk_point(FxOne / 2, FxOne / 2));
		drain_results();
		// zero threshold, single step: any escape lands on step zero
		set_register(REG_MAX_ITER, 31'd1);
		set_register(REG_ESCAPE_LIMIT, 31'd0);
		send_point(mk_point(0, 0));
		send_point(mk_point(1, 0));
		send_point(mk_point(-FxTwo, -FxTwo));
		drain_results();
		// norm saturates at the threshold, so nothing ever escapes
		set_register(REG_MAX_ITER, 31'd255);
		set_register(REG_ESCAPE_LIMIT, LimitTop);
		send_point(mk_point(InMin, InMax));
		send_point(mk_point(FxTwo, FxTwo));
		drain_results();
		set_register(REG_ESCAPE_LIMIT, LimitHigh);
		send_point(mk_point(FxOne / 4 + FxOne / 1024, 0));
		send_point(mk_point(-FxTwo, 0));
		send_point(mk_point(-3 * FxOne / 4, FxOne / 64));
		drain_results();
		// writes to spare indexes must leave both registers alone
		set_register(RegSpare2, 31'd3);
		set_register(RegSpare3, 31'($urandom));
		send_point(mk_point(FxOne / 4 + FxOne / 1024, 0));
		send_point(mk_point(FxOne, FxOne));
		drain_results();
		set_register(REG_MAX_ITER, 31'(MaxIterReset));
		set_register(REG_ESCAPE_LIMIT, LimitReset);
	endtask

	task automatic test_output_backpressure();
		set_register(REG_MAX_ITER, 31'd6);
		steady_in = 1'b1;
		long_hold_req = 1'b1;
		repeat (16) send_point(random_point());
		steady_in = 1'b0;
		drain_results();
	endtask

	task automatic test_random_phases();
		logic [CfgDataWidth-1:0] iters;
		logic [CfgDataWidth-1:0] limit;
		for (int ph = 0; ph < PhaseCount; ph++) begin
			case (ph % 6)
				0: begin
					iters = 31'(MaxIterReset);
					limit = LimitReset;
				end
				1: begin
					iters = 31'($urandom_range(1, 12));
					limit = 31'($urandom_range(0, 1 << 30));
				end
				2: begin
					iters = 31'($urandom_range(13, 64));
					limit = LimitFour;
				end
				3: begin
					iters = (ph == 3) ? 31'd255 : 31'd0;
					limit = 31'($urandom_range(0, 1 << 30));
				end
				4: begin
					iters = 31'($urandom_range(1, 100));
					limit = 31'($urandom);
				end
				default: begin
					iters = 31'($urandom_range(1, 30));
					limit = 31'd0;
				end
			endcase
			set_register(REG_MAX_ITER, iters);
			set_register(REG_ESCAPE_LIMIT, limit);
			steady_in  = (ph == 2) || (ph == 7);
			steady_out = (ph == 2) || (ph == 8);
			repeat (PhaseItems) send_point(random_point());
			drain_results();
		end
		steady_in  = 1'b0;
		steady_out = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LongHold - 1;
			m_axis_tready <= 1'b0;
		end else if (steady_out) begin
			m_axis_tready <= 1'b1;
		end else begin
			hold_left = idle_len();
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pixel_fifo.size() == 0) begin
				$error("result transfer with no point outstanding: tdata %h tuser %b",
					m_axis_tdata, m_axis_tuser);
				mismatch_count++;
			end else begin
				pixel_want = pixel_fifo.pop_front();
				compare_field("escape_count", pixel_want.count, m_axis_tdata[7:0]);
				compare_field("inside_set", pixel_want.in_set, m_axis_tuser);
				compare_field("red", pixel_want.red, m_axis_tdata[15:8]);
				compare_field("green", pixel_want.green, m_axis_tdata[23:16]);
				compare_field("blue", pixel_want.blue, m_axis_tdata[31:24]);
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_output_backpressure();
		test_random_phases();
		drain_results();
		repeat (TailCycles) @(posedge clk);
		if (mismatch_count == 0 && pixel_fifo.size() == 0) begin
			$display("tb_mandelbrot_escape_iterator: clean");
		end else begin
			$display("tb_mandelbrot_escape_iterator: errors");
		end
		$finish;
	end

	initial begin
		#(TimeLimitNs);
		$error("run did not finish in time, %0d results outstanding", pixel_fifo.size());
		$display("tb_mandelbrot_escape_iterator: errors");
		$finish;
	end

endmodule
